>>> rtl/core/rcp_pkg.sv
// rcp_pkg: shared types, limits and character codes of the request parser.
// Used by every module under rtl/core; depends on nothing.
package rcp_pkg;

	localparam int unsigned COUNT_LIMIT  = 1024;
	localparam int unsigned LENGTH_LIMIT = 512 * 1024 * 1024;
	localparam int unsigned LINE_LIMIT   = 64;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned LEN_W    = 30;
	localparam int unsigned LINE_W   = 7;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [LEN_W-1:0]  SAT_VALUE = {LEN_W{1'b1}};
	localparam logic [LINE_W-1:0] LINE_SAT  = {LINE_W{1'b1}};

	localparam logic [COUNT_W-1:0] RST_MAX_ARG_COUNT   = COUNT_W'(COUNT_LIMIT);
	localparam logic [LEN_W-1:0]   RST_MAX_ARG_LENGTH  = LEN_W'(LENGTH_LIMIT);
	localparam logic [LINE_W-1:0]  RST_MAX_NUMBER_LINE = LINE_W'(LINE_LIMIT);

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARG_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_NUMBER_LINE = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_ARG_DONE,
		KIND_CMD_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NO_ARRAY,
		ERR_BAD_COUNT,
		ERR_NO_BULK,
		ERR_BAD_LENGTH,
		ERR_NO_CRLF
	} err_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              clear;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  payload;
		logic [INDEX_W-1:0] arg_index;
		logic [LEN_W-1:0]   amount;
		err_t               error_code;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic              clear;
		logic [BYTE_W-1:0] data;
		logic              is_digit;
		logic [3:0]        digit;
		logic              is_cr;
		logic              is_lf;
		logic              is_star;
		logic              is_dollar;
		logic              is_minus;
	} class_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [LEN_W-1:0]     data;
	} cfg_wr_t;

endpackage

>>> rtl/core/rcp_front.sv
// rcp_front: input stage; registers each item and decodes its byte class.
// Depends on rcp_pkg; feeds rcp_queue.
module rcp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_ready,
	input  rcp_pkg::in_item_t byte_item,
	output logic              push,
	output rcp_pkg::class_t   push_data,
	input  logic              q_full
);

	logic            valid_s1;
	rcp_pkg::class_t cls_s1;
	rcp_pkg::class_t cls;

	always_comb begin
		cls.clear     = byte_item.clear;
		cls.data      = byte_item.in_byte;
		cls.is_digit  = (byte_item.in_byte >= rcp_pkg::CH_ZERO) &&
			(byte_item.in_byte <= rcp_pkg::CH_NINE);
		cls.digit     = 4'(byte_item.in_byte - rcp_pkg::CH_ZERO);
		cls.is_cr     = byte_item.in_byte == rcp_pkg::CH_CR;
		cls.is_lf     = byte_item.in_byte == rcp_pkg::CH_LF;
		cls.is_star   = byte_item.in_byte == rcp_pkg::CH_STAR;
		cls.is_dollar = byte_item.in_byte == rcp_pkg::CH_DOLLAR;
		cls.is_minus  = byte_item.in_byte == rcp_pkg::CH_MINUS;
	end

	assign push       = valid_s1 && !q_full;
	assign byte_ready = !valid_s1 || !q_full;
	assign push_data  = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			cls_s1 <= cls;
		end
	end

endmodule

>>> rtl/core/rcp_queue.sv
// rcp_queue: short FIFO of classified items between front and back.
// Depends on rcp_pkg.
module rcp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rcp_pkg::class_t push_data,
	output logic            full,
	input  logic            pop,
	output rcp_pkg::class_t pop_data,
	output logic            nonempty
);

	rcp_pkg::class_t                mem_q [rcp_pkg::QUEUE_DEPTH];
	logic [rcp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [rcp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [rcp_pkg::QCNT_W-1:0]     count_q;

	localparam logic [rcp_pkg::QPTR_W-1:0] PTR_LAST = rcp_pkg::QPTR_W'(rcp_pkg::QUEUE_DEPTH - 1);

	assign full     = count_q == rcp_pkg::QCNT_W'(rcp_pkg::QUEUE_DEPTH);
	assign nonempty = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/rcp_exec.sv
// rcp_exec: back end; parser state machine, config registers and result register.
// Depends on rcp_pkg; drains rcp_queue.
module rcp_exec (
	input  logic               clk,
	input  logic               arst_n,
	input  rcp_pkg::cfg_wr_t   cfg,
	input  logic               q_nonempty,
	input  rcp_pkg::class_t    cls,
	output logic               q_pop,
	output logic               result_valid,
	input  logic               result_ready,
	output rcp_pkg::out_item_t result_item
);

	typedef enum logic [3:0] {
		PH_STAR,
		PH_CNT,
		PH_CNT_LF,
		PH_DOLLAR,
		PH_LEN,
		PH_LEN_LF,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF
	} phase_t;

	localparam int unsigned LEN_W  = rcp_pkg::LEN_W;
	localparam int unsigned CNT_W  = rcp_pkg::COUNT_W;
	localparam int unsigned LINE_W = rcp_pkg::LINE_W;
	localparam int unsigned ACC_W  = LEN_W + 4;

	logic [CNT_W-1:0]  max_arg_count_q;
	logic [LEN_W-1:0]  max_arg_length_q;
	logic [LINE_W-1:0] max_number_line_q;

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  nv_q, nv_d;
	logic              over_q, over_d;
	logic              minus_q, minus_d;
	logic              digit_q, digit_d;
	logic [LINE_W-1:0] ll_q, ll_d;
	logic [CNT_W-1:0]  total_q, total_d;
	logic [CNT_W-1:0]  cur_q, cur_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic [LEN_W-1:0]  alen_q, alen_d;
	logic              halted_q, halted_d;

	logic               out_valid_q;
	rcp_pkg::out_item_t out_q;
	logic               pend_valid_q;
	rcp_pkg::out_item_t pend_q;

	logic               out_free;
	logic               take;
	rcp_pkg::out_item_t r0, r1;
	logic               r0_v, r1_v;
	logic               fail;
	rcp_pkg::err_t      code;

	logic [LEN_W-1:0]  cnt_lim, len_lim;
	logic [LINE_W-1:0] line_lim;
	logic [LINE_W-1:0] ll_next;
	logic [ACC_W-1:0]  acc;
	logic              acc_ovf;
	logic              num_base_ok;
	logic [CNT_W-1:0]  cur_inc;

	function automatic rcp_pkg::out_item_t mk_res(
		input rcp_pkg::kind_t                kind,
		input logic [rcp_pkg::BYTE_W-1:0]    payload,
		input logic [rcp_pkg::INDEX_W-1:0]   idx,
		input logic [rcp_pkg::LEN_W-1:0]     amt,
		input rcp_pkg::err_t                 ecode,
		input logic                          last
	);
		rcp_pkg::out_item_t r;
		r.kind       = kind;
		r.payload    = payload;
		r.arg_index  = idx;
		r.amount     = amt;
		r.error_code = ecode;
		r.last       = last;
		return r;
	endfunction

	assign cnt_lim = (LEN_W'(max_arg_count_q) < LEN_W'(rcp_pkg::COUNT_LIMIT)) ?
		LEN_W'(max_arg_count_q) : LEN_W'(rcp_pkg::COUNT_LIMIT);
	assign len_lim = (max_arg_length_q < LEN_W'(rcp_pkg::LENGTH_LIMIT)) ?
		max_arg_length_q : LEN_W'(rcp_pkg::LENGTH_LIMIT);
	assign line_lim = (max_number_line_q < LINE_W'(rcp_pkg::LINE_LIMIT)) ?
		max_number_line_q : LINE_W'(rcp_pkg::LINE_LIMIT);

	assign ll_next = (ll_q != rcp_pkg::LINE_SAT) ? ll_q + 1'b1 : ll_q;
	assign acc = ({4'b0, nv_q} << 3) + ({4'b0, nv_q} << 1) + ACC_W'(cls.digit);
	assign acc_ovf = acc > ACC_W'(rcp_pkg::SAT_VALUE);
	assign num_base_ok = digit_q && !over_q && !(minus_q && nv_q != '0);
	assign cur_inc = cur_q + 1'b1;

	assign out_free = !out_valid_q || result_ready;
	assign take     = q_nonempty && out_free && !pend_valid_q;
	assign q_pop    = take;

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	always_comb begin
		phase_d  = phase_q;
		nv_d     = nv_q;
		over_d   = over_q;
		minus_d  = minus_q;
		digit_d  = digit_q;
		ll_d     = ll_q;
		total_d  = total_q;
		cur_d    = cur_q;
		left_d   = left_q;
		alen_d   = alen_q;
		halted_d = halted_q;
		r0       = '0;
		r1       = '0;
		r0_v     = 1'b0;
		r1_v     = 1'b0;
		fail     = 1'b0;
		code     = rcp_pkg::ERR_NO_ARRAY;
		if (cls.clear) begin
			phase_d  = PH_STAR;
			nv_d     = '0;
			over_d   = 1'b0;
			minus_d  = 1'b0;
			digit_d  = 1'b0;
			ll_d     = '0;
			total_d  = '0;
			cur_d    = '0;
			left_d   = '0;
			alen_d   = '0;
			halted_d = 1'b0;
		end else if (!halted_q) begin
			unique case (phase_q)
				PH_STAR: begin
					code = rcp_pkg::ERR_NO_ARRAY;
					if (!cls.is_star) begin
						fail = 1'b1;
					end else begin
						cur_d   = '0;
						phase_d = PH_CNT;
						nv_d    = '0;
						over_d  = 1'b0;
						minus_d = 1'b0;
						digit_d = 1'b0;
						ll_d    = '0;
					end
				end
				PH_CNT, PH_LEN: begin
					code = (phase_q == PH_CNT) ? rcp_pkg::ERR_BAD_COUNT :
						rcp_pkg::ERR_BAD_LENGTH;
					ll_d = ll_next;
					priority if (ll_next > line_lim) begin
						fail = 1'b1;
					end else if (cls.is_cr) begin
						phase_d = (phase_q == PH_CNT) ? PH_CNT_LF : PH_LEN_LF;
					end else if (cls.is_minus && ll_next == LINE_W'(1)) begin
						minus_d = 1'b1;
					end else if (cls.is_digit) begin
						nv_d    = acc_ovf ? rcp_pkg::SAT_VALUE : acc[LEN_W-1:0];
						over_d  = over_q || acc_ovf;
						digit_d = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_CNT_LF: begin
					code = rcp_pkg::ERR_BAD_COUNT;
					if (!cls.is_lf || !num_base_ok || nv_q > cnt_lim) begin
						fail = 1'b1;
					end else begin
						total_d = nv_q[CNT_W-1:0];
						cur_d   = '0;
						if (nv_q == '0) begin
							phase_d = PH_STAR;
							r0_v    = 1'b1;
							r0      = mk_res(rcp_pkg::KIND_CMD_DONE, '0, '0, '0,
								rcp_pkg::ERR_NO_ARRAY, 1'b1);
						end else begin
							phase_d = PH_DOLLAR;
						end
					end
				end
				PH_DOLLAR: begin
					code = rcp_pkg::ERR_NO_BULK;
					if (!cls.is_dollar) begin
						fail = 1'b1;
					end else begin
						phase_d = PH_LEN;
						nv_d    = '0;
						over_d  = 1'b0;
						minus_d = 1'b0;
						digit_d = 1'b0;
						ll_d    = '0;
					end
				end
				PH_LEN_LF: begin
					code = rcp_pkg::ERR_BAD_LENGTH;
					if (!cls.is_lf || !num_base_ok || nv_q > len_lim) begin
						fail = 1'b1;
					end else begin
						alen_d  = nv_q;
						left_d  = nv_q;
						phase_d = (nv_q != '0) ? PH_DATA : PH_DATA_CR;
					end
				end
				PH_DATA: begin
					r0_v = 1'b1;
					r0   = mk_res(rcp_pkg::KIND_BYTE, cls.data,
						cur_q[rcp_pkg::INDEX_W-1:0], '0, rcp_pkg::ERR_NO_ARRAY, 1'b1);
					left_d = left_q - 1'b1;
					if (left_q == LEN_W'(1)) begin
						phase_d = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					code = rcp_pkg::ERR_NO_CRLF;
					if (!cls.is_cr) begin
						fail = 1'b1;
					end else begin
						phase_d = PH_DATA_LF;
					end
				end
				PH_DATA_LF: begin
					code = rcp_pkg::ERR_NO_CRLF;
					if (!cls.is_lf) begin
						fail = 1'b1;
					end else if (cur_inc >= total_q) begin
						r0_v    = 1'b1;
						r0      = mk_res(rcp_pkg::KIND_ARG_DONE, '0,
							cur_q[rcp_pkg::INDEX_W-1:0], alen_q, rcp_pkg::ERR_NO_ARRAY, 1'b0);
						r1_v    = 1'b1;
						r1      = mk_res(rcp_pkg::KIND_CMD_DONE, '0, '0, LEN_W'(total_q),
							rcp_pkg::ERR_NO_ARRAY, 1'b1);
						phase_d = PH_STAR;
						cur_d   = '0;
					end else begin
						r0_v    = 1'b1;
						r0      = mk_res(rcp_pkg::KIND_ARG_DONE, '0,
							cur_q[rcp_pkg::INDEX_W-1:0], alen_q, rcp_pkg::ERR_NO_ARRAY, 1'b1);
						phase_d = PH_DOLLAR;
						cur_d   = cur_inc;
					end
				end
				default: begin
					phase_d = PH_STAR;
					nv_d    = '0;
					over_d  = 1'b0;
					minus_d = 1'b0;
					digit_d = 1'b0;
					ll_d    = '0;
				end
			endcase
			if (fail) begin
				halted_d = 1'b1;
				r0_v     = 1'b1;
				r0       = mk_res(rcp_pkg::KIND_ERROR, '0, cur_q[rcp_pkg::INDEX_W-1:0],
					'0, code, 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_arg_count_q   <= rcp_pkg::RST_MAX_ARG_COUNT;
			max_arg_length_q  <= rcp_pkg::RST_MAX_ARG_LENGTH;
			max_number_line_q <= rcp_pkg::RST_MAX_NUMBER_LINE;
			phase_q      <= PH_STAR;
			nv_q         <= '0;
			over_q       <= 1'b0;
			minus_q      <= 1'b0;
			digit_q      <= 1'b0;
			ll_q         <= '0;
			total_q      <= '0;
			cur_q        <= '0;
			left_q       <= '0;
			alen_q       <= '0;
			halted_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					rcp_pkg::CFG_MAX_ARG_COUNT:   max_arg_count_q   <= cfg.data[CNT_W-1:0];
					rcp_pkg::CFG_MAX_ARG_LENGTH:  max_arg_length_q  <= cfg.data;
					rcp_pkg::CFG_MAX_NUMBER_LINE: max_number_line_q <= cfg.data[LINE_W-1:0];
					default: ;
				endcase
			end
			if (out_free) begin
				if (pend_valid_q) begin
					out_q        <= pend_q;
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else if (take && r0_v) begin
					out_q        <= r0;
					out_valid_q  <= 1'b1;
					pend_valid_q <= r1_v;
					pend_q       <= r1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
			if (take) begin
				phase_q  <= phase_d;
				nv_q     <= nv_d;
				over_q   <= over_d;
				minus_q  <= minus_d;
				digit_q  <= digit_d;
				ll_q     <= ll_d;
				total_q  <= total_d;
				cur_q    <= cur_d;
				left_q   <= left_d;
				alen_q   <= alen_d;
				halted_q <= halted_d;
			end
		end
	end

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending result without a result in the output register");

	a_pend_is_cmd_done: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (pend_q.kind == rcp_pkg::KIND_CMD_DONE) && pend_q.last)
		else $error("second result of an item is not a final command-done");

	a_not_last_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last) |-> pend_valid_q)
		else $error("non-final result with no follow-up queued");

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (left_q != '0))
		else $error("payload phase with zero bytes left");

endmodule

>>> rtl/core/resp_command_parser.sv
// resp_command_parser: top level of the multibulk request parser.
// Depends on rcp_pkg, rcp_front, rcp_queue and rcp_exec.
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item): one stream byte per item,
//     or a clear item that returns the parser to expecting a new command.
//   result channel (result_valid/result_ready/result_item): payload bytes,
//     argument-done, command-done and error items; last marks the final
//     item caused by one input byte.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0
//     max_arg_count, 1 max_arg_length, 2 max_number_line, others ignored.
//     Write only while the parser is idle.
// Path: an accepted byte is registered in the input stage, written into the queue,
//   popped by the back end, and its first result goes to the output register.
// Throughput: one byte per cycle unless the receiver stalls; the closing LF of a
//   command's last argument yields two items, and the second stalls the back end.
// Reset: limits return to their defaults, the parser expects '*', queue empty.
// When the receiver stalls the output register and pending item hold, the
//   back end stops, and the 4-item queue plus input stage fill before
//   byte_ready drops.
module resp_command_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_ready,
	input  rcp_pkg::in_item_t                 byte_item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output rcp_pkg::out_item_t                result_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcp_pkg::LEN_W-1:0]         cfg_data
);

	logic             push;
	rcp_pkg::class_t  push_data;
	logic             q_full;
	logic             q_pop;
	rcp_pkg::class_t  pop_data;
	logic             q_nonempty;
	rcp_pkg::cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	rcp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	rcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.nonempty  (q_nonempty)
	);

	rcp_exec u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_nonempty   (q_nonempty),
		.cls          (pop_data),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule
